[hdl/icd_pkg.sv]
// Shared types and constants for the impact cadence detector.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps

package icd_pkg;

  localparam int ACT_W       = 14;
  localparam int TS_W        = 16;
  localparam int PERIOD_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int SCALE_SHIFT = 4;

  localparam logic [ACT_W-1:0]    RESET_THRESHOLD = 14'd1500;
  localparam logic [PERIOD_W-1:0] RESET_PERIOD    = 16'd1000;
  // Nine tenths of the reset period limit, floor(1000 / 10) * 9.
  localparam logic [PERIOD_W-1:0] RESET_PERIOD_NINE = 16'd900;

  // Floor division of a 16-bit value by ten: (x * 0xCCCD) >> 19 is exact.
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          DIV10_SHIFT = 19;
  localparam int          DIV10_Q_W   = 13;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HIT_LEVEL    = 3'd0,
    REG_PERIOD_LIMIT = 3'd1,
    REG_OFFSET_X     = 3'd2,
    REG_OFFSET_Y     = 3'd3,
    REG_OFFSET_Z     = 3'd4
  } cfg_reg_t;

  // One classified sample waiting for the event logic.
  typedef struct packed {
    logic [ACT_W-1:0] activity;
    logic [TS_W-1:0]  timestamp;
  } sample_entry_t;

  // Settings seen by the event logic.
  typedef struct packed {
    logic [ACT_W-1:0]    threshold;
    logic [PERIOD_W-1:0] limit;
    logic [PERIOD_W-1:0] limit_nine;
  } event_cfg_t;

endpackage

[hdl/icd_front.sv]
// Front end: takes samples, removes offsets, scales and computes activity.
// Depends on icd_pkg; feeds icd_queue.
`timescale 1ns / 1ps

module icd_front import icd_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [15:0]            accel_x,
  input  logic [15:0]            accel_y,
  input  logic [15:0]            accel_z,
  input  logic [TS_W-1:0]        timestamp,
  input  logic [SAMPLE_BITS-1:0] offset_x,
  input  logic [SAMPLE_BITS-1:0] offset_y,
  input  logic [SAMPLE_BITS-1:0] offset_z,
  input  logic                   q_full,
  output logic                   push,
  output sample_entry_t          push_data
);

  localparam int SCALED_W = SAMPLE_BITS - SCALE_SHIFT;
  localparam int SUM_W    = SCALED_W + 2;

  logic [SAMPLE_BITS-1:0] raw     [3];
  logic [SAMPLE_BITS-1:0] off     [3];
  logic [SAMPLE_BITS-1:0] wrapped [3];
  logic [SCALED_W-1:0]    scaled  [3];
  logic [SCALED_W-1:0]    prev    [3];
  logic [SCALED_W:0]      diff    [3];
  logic [SCALED_W-1:0]    mag     [3];
  logic [SUM_W-1:0]       sum;

  assign raw[0] = accel_x[SAMPLE_BITS-1:0];
  assign raw[1] = accel_y[SAMPLE_BITS-1:0];
  assign raw[2] = accel_z[SAMPLE_BITS-1:0];
  assign off[0] = offset_x;
  assign off[1] = offset_y;
  assign off[2] = offset_z;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wrapped[i] = raw[i] - off[i];
      // Arithmetic shift right, kept at the scaled width: the top bits.
      scaled[i]  = wrapped[i][SAMPLE_BITS-1:SCALE_SHIFT];
      diff[i]    = {scaled[i][SCALED_W-1], scaled[i]} - {prev[i][SCALED_W-1], prev[i]};
      mag[i]     = diff[i][SCALED_W] ? SCALED_W'(-diff[i]) : diff[i][SCALED_W-1:0];
    end
    sum = SUM_W'(mag[0]) + SUM_W'(mag[1]) + SUM_W'(mag[2]);
  end

  assign push_data.activity  = ACT_W'(sum);
  assign push_data.timestamp = timestamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        prev[i] <= '0;
      end
    end else if (push) begin
      for (int i = 0; i < 3; i++) begin
        prev[i] <= scaled[i];
      end
    end
  end

endmodule

[hdl/icd_queue.sv]
// Short queue between the front end and the event logic.
// Depends on icd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module icd_queue import icd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sample_entry_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output sample_entry_t head
);

  sample_entry_t          mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full    = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/icd_back.sv]
// Back end: impact and stop detection, period averaging, result register.
// Depends on icd_pkg; drains icd_queue.
`timescale 1ns / 1ps

module icd_back import icd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  sample_entry_t       head,
  output logic                pop,
  input  event_cfg_t          cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ACT_W-1:0]    activity,
  output logic                impact,
  output logic                stop_event,
  output logic [PERIOD_W-1:0] average_period,
  output logic                is_stopped
);

  logic [ACT_W-1:0]    prev_activity;
  logic [TS_W-1:0]     last_event_time;
  logic [PERIOD_W-1:0] period_average;
  logic                stopped_flag;

  logic [TS_W-1:0]     elapsed;
  logic [PERIOD_W:0]   avg_sum;
  logic                stop_hit;
  logic                impact_hit;
  logic                stopped_mid;
  logic [TS_W-1:0]     last_event_time_next;
  logic [PERIOD_W-1:0] period_average_next;
  logic                stopped_flag_next;

  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    elapsed     = head.timestamp - last_event_time;
    avg_sum     = {1'b0, period_average} + {1'b0, elapsed};
    stop_hit    = (elapsed > cfg.limit) && !stopped_flag;
    impact_hit  = (head.activity > cfg.threshold) && (prev_activity <= cfg.threshold);
    stopped_mid = stopped_flag || stop_hit;

    last_event_time_next = (stop_hit || impact_hit) ? head.timestamp : last_event_time;
    stopped_flag_next    = impact_hit ? 1'b0 : stopped_mid;
    if (impact_hit) begin
      period_average_next = stopped_mid ? cfg.limit_nine : avg_sum[PERIOD_W:1];
    end else if (stop_hit) begin
      period_average_next = cfg.limit;
    end else begin
      period_average_next = period_average;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_activity   <= '0;
      last_event_time <= '0;
      period_average  <= RESET_PERIOD;
      stopped_flag    <= 1'b1;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        prev_activity   <= head.activity;
        last_event_time <= last_event_time_next;
        period_average  <= period_average_next;
        stopped_flag    <= stopped_flag_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      activity       <= head.activity;
      impact         <= impact_hit;
      stop_event     <= stop_hit;
      average_period <= period_average_next;
      is_stopped     <= stopped_flag_next;
    end
  end

endmodule

[hdl/impact_cadence_detector_core.sv]
// Top level of the impact cadence detector: configuration registers and wiring.
// Depends on icd_pkg, icd_front, icd_queue and icd_back.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ----------------------------------------
// input     in         in_valid / in_ready       accel_x, accel_y, accel_z, timestamp
// output    out        out_valid / out_ready     activity, impact, stop_event,
//                                                average_period, is_stopped
// config    in         cfg_write (no wait)       cfg_index, cfg_data
//
// One sample per clock is sustained while out_ready stays high. A transfer on the input
// lands in the queue at the same edge; the event logic then pops it and loads the result
// register, which raises out_valid.
// Reset (synchronous, rst high) restores the control registers to their defaults and
// empties the queue and the output register. A stalled output holds its result while the
// two-entry queue keeps absorbing samples; in_ready drops only once the queue is full.

module impact_cadence_detector_core import icd_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [15:0]            accel_x,
  input  logic [15:0]            accel_y,
  input  logic [15:0]            accel_z,
  input  logic [TS_W-1:0]        timestamp,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ACT_W-1:0]       activity,
  output logic                   impact,
  output logic                   stop_event,
  output logic [PERIOD_W-1:0]    average_period,
  output logic                   is_stopped,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers. The nine-tenths period value is worked out when the
  // period limit is written, so the event logic sees it as a plain register.
  logic [ACT_W-1:0]       hit_level;
  logic [PERIOD_W-1:0]    period_limit;
  logic [PERIOD_W-1:0]    period_nine;
  logic [SAMPLE_BITS-1:0] offset_x;
  logic [SAMPLE_BITS-1:0] offset_y;
  logic [SAMPLE_BITS-1:0] offset_z;

  logic [32:0]            div10_prod;
  logic [DIV10_Q_W-1:0]   div10_q;
  logic [PERIOD_W-1:0]    nine_tenths;

  // Floor of the written limit over ten, by reciprocal multiply, then times nine.
  assign div10_prod  = 33'(cfg_data) * 33'(DIV10_MUL);
  assign div10_q     = div10_prod[DIV10_SHIFT +: DIV10_Q_W];
  assign nine_tenths = PERIOD_W'({div10_q, 3'b000}) + PERIOD_W'(div10_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_level    <= RESET_THRESHOLD;
      period_limit <= RESET_PERIOD;
      period_nine  <= RESET_PERIOD_NINE;
      offset_x     <= '0;
      offset_y     <= '0;
      offset_z     <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_HIT_LEVEL: hit_level <= cfg_data[ACT_W-1:0];
        REG_PERIOD_LIMIT: begin
          period_limit <= cfg_data[PERIOD_W-1:0];
          period_nine  <= nine_tenths;
        end
        REG_OFFSET_X: offset_x <= cfg_data[SAMPLE_BITS-1:0];
        REG_OFFSET_Y: offset_y <= cfg_data[SAMPLE_BITS-1:0];
        REG_OFFSET_Z: offset_z <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  event_cfg_t    event_cfg;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  sample_entry_t q_in;
  sample_entry_t q_head;

  assign event_cfg.threshold  = hit_level;
  assign event_cfg.limit      = period_limit;
  assign event_cfg.limit_nine = period_nine;

  // Front end: the scaled axes of the last sample live here, so activity is
  // complete before the sample enters the queue.
  icd_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .timestamp (timestamp),
    .offset_x  (offset_x),
    .offset_y  (offset_y),
    .offset_z  (offset_z),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  icd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .head      (q_head)
  );

  // Back end: owns the timing state (last event, averaged period, stopped flag)
  // and the output register.
  icd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .head           (q_head),
    .pop            (q_pop),
    .cfg            (event_cfg),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .activity       (activity),
    .impact         (impact),
    .stop_event     (stop_event),
    .average_period (average_period),
    .is_stopped     (is_stopped)
  );

  // An impact always clears the stopped flag.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && impact |-> !is_stopped)
    else $error("impact reported while still stopped");

  // A stop without an impact on the same sample leaves the block stopped.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_event && !impact |-> is_stopped)
    else $error("stop event without the stopped flag");

  // An impact needs activity above the threshold.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && impact |-> activity > hit_level)
    else $error("impact reported at or below the threshold");

  // Back-pressure on the input only comes from a queue holding work.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("input stalled with an empty queue");

endmodule
